### sv/sprite_scanline_rle_packer_core_defines.svh
// assertion macros for the scanline packer
// no dependencies
`ifndef SPRITE_SCANLINE_RLE_PACKER_CORE_DEFINES_SVH
`define SPRITE_SCANLINE_RLE_PACKER_CORE_DEFINES_SVH
`define SSRP_ASSERT_IMP(lbl, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define SSRP_ASSERT_NXT(lbl, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

### sv/ssrp_pkg.sv
// types and constants of the scanline packer
// no dependencies
package ssrp_pkg;
	typedef struct packed {
		logic [3:0] pixel;
		logic       opaque;
		logic       line_end;
	} in_t;
	typedef struct packed {
		logic [7:0] out_byte;
		logic       final_byte;
	} out_t;
	localparam logic [1:0] MODE_LIT = 2'd0;
	localparam logic [1:0] MODE_PACKED = 2'd1;
	localparam logic [1:0] MODE_SHAPED = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_CBITS = 2'd1;
	localparam int MAX_DATA = 63;
	localparam int MAX_PACKET = 16;
	typedef enum logic [10:0] {
		ST_LOAD  = 11'b00000000001,
		ST_SETUP = 11'b00000000010,
		ST_ARD   = 11'b00000000100,
		ST_ASCAN = 11'b00000001000,
		ST_DEC   = 11'b00000010000,
		ST_HDR   = 11'b00000100000,
		ST_PRD   = 11'b00001000000,
		ST_PIX   = 11'b00010000000,
		ST_CLOSE = 11'b00100000000,
		ST_EMIT  = 11'b01000000000,
		ST_ERD   = 11'b10000000000
	} state_t;
endpackage

### sv/ssrp_line_mem.sv
// line store for pixels of one scanline, one write and one registered read
// depends on nothing
module ssrp_line_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [3:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [3:0]    rdata
);
	logic [3:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### sv/ssrp_byte_mem.sv
// byte store for the encoded data of one scanline
// depends on nothing
module ssrp_byte_mem (
	input  logic       clk,
	input  logic       we,
	input  logic [5:0] waddr,
	input  logic [7:0] wdata,
	input  logic [5:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [64];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### sv/sprite_scanline_rle_packer_core.sv
// scanline packer top level: load, window analysis, bit packing, byte output
// depends on ssrp_pkg, ssrp_line_mem, ssrp_byte_mem, defines header
//  channel | dir | handshake
//  in      | in  | in_valid / in_ready, ssrp_pkg::in_t
//  out     | out | out_valid / out_ready, ssrp_pkg::out_t
//  apb     | in  | psel penable pwrite paddr pwdata prdata pready
// pixels load one per cycle; at line_end setup runs, then the line is encoded
// literal: each pixel is read, then packed; packed/shaped: each analysis pass reads its
// window and decides; each header is packed, each emitted pixel is read, then packed
// at line done, closing writes the last byte, plus a zero pad byte if it is alone;
// then the count byte and each data byte go out; output stalls hold the byte in place
// no request is taken until the last byte of the line has been delivered
// reset clears control state only; memories need no clearing
`include "sprite_scanline_rle_packer_core_defines.svh"
module sprite_scanline_rle_packer_core #(
	parameter int MAX_PIXELS = 64,
	parameter int WINDOW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ssrp_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ssrp_pkg::out_t  out_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	localparam int AW = $clog2(MAX_PIXELS);
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int WW = $clog2(WINDOW + 1);

	ssrp_pkg::state_t st_q;
	logic [1:0] mode_q;
	logic [2:0] cbits_q;
	logic [CW-1:0] cnt_q, lastop_q, len_q, pos_q;
	logic seen_q;
	logic [WW-1:0] alen_q, k_q;
	logic [3:0] prev_q;
	logic prev_ok_q;
	logic [WW-1:0] run_q, longest_q, lpos_q;
	logic lit_q;
	logic [4:0] n_q;
	logic [7:0] acc_q;
	logic [3:0] free_q;
	logic [6:0] bc_q;
	logic [6:0] ei_q;
	logic [3:0] rd4;
	logic [7:0] rd8;
	logic [AW-1:0] lraddr;
	logic [5:0] braddr;
	logic bwe;
	logic [7:0] bwd;
	logic [2:0] cb;
	logic [3:0] mask, pv;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			ssrp_pkg::REG_MODE[0]: prdata = {30'd0, mode_q};
			default: prdata = {29'd0, cbits_q};
		endcase
	end
	always_comb begin
		if (cbits_q == 3'd0) cb = 3'd1;
		else if (cbits_q > 3'd4) cb = 3'd4;
		else cb = cbits_q;
	end
	assign mask = 4'((5'd1 << cb) - 5'd1);
	assign pv = rd4 & mask;

	assign in_ready = (st_q == ssrp_pkg::ST_LOAD);
	wire in_acc = in_valid && in_ready;
	wire lwe = in_acc && (cnt_q < CW'(MAX_PIXELS));

	ssrp_line_mem #(.DEPTH(MAX_PIXELS), .AW(AW)) u_line (
		.clk(clk), .we(lwe), .waddr(cnt_q[AW-1:0]), .wdata(in_data.pixel),
		.raddr(lraddr), .rdata(rd4)
	);
	ssrp_byte_mem u_bytes (
		.clk(clk), .we(bwe), .waddr(bc_q[5:0]), .wdata(bwd),
		.raddr(braddr), .rdata(rd8)
	);

	// bit packer: appends w bits (<=5) of val to the accumulator
	logic [7:0] pk_acc;
	logic [3:0] pk_free;
	logic pk_push;
	logic [7:0] pk_byte;
	logic [4:0] put_val;
	logic [2:0] put_w;
	logic do_put;
	always_comb begin
		logic [12:0] wide;
		wide = {5'd0, acc_q} << put_w;
		wide = wide | 13'(put_val & 5'((6'd1 << put_w) - 6'd1));
		pk_push = 1'b0;
		pk_byte = 8'd0;
		if ({1'b0, put_w} >= free_q) begin
			pk_push = 1'b1;
			pk_byte = 8'(wide >> (4'(put_w) - free_q));
			pk_free = 4'd8 - (4'(put_w) - free_q);
			pk_acc = 8'(wide) & 8'((9'd1 << (4'(put_w) - free_q)) - 9'd1);
		end else begin
			pk_free = free_q - 4'(put_w);
			pk_acc = 8'(wide);
		end
	end

	// analysis scan step helpers
	wire [CW-1:0] rem = len_q - pos_q;
	wire [WW-1:0] a_inc_run = run_q + 1'b1;
	wire [WW-1:0] remw = (rem > CW'(WINDOW)) ? WW'(WINDOW) : WW'(rem);
	function automatic logic [4:0] capf(input logic [WW-1:0] x);
		capf = (x > WW'(ssrp_pkg::MAX_PACKET)) ? 5'd16 : 5'(x);
	endfunction

	always_comb begin
		lraddr = pos_q[AW-1:0] + AW'(k_q);
		braddr = ei_q[5:0] - 6'd1;
		put_val = 5'd0;
		put_w = 3'd0;
		do_put = 1'b0;
		unique case (st_q)
			ssrp_pkg::ST_HDR: begin
				put_val = lit_q ? ((n_q - 5'd1) | 5'h10) : (n_q - 5'd1);
				put_w = 3'd5;
				do_put = 1'b1;
			end
			ssrp_pkg::ST_PIX: begin
				put_val = {1'b0, pv};
				put_w = cb;
				do_put = 1'b1;
			end
			ssrp_pkg::ST_PRD: lraddr = pos_q[AW-1:0];
			ssrp_pkg::ST_ERD: braddr = ei_q[5:0];
			default: begin end
		endcase
	end

	logic close_pad;
	always_comb begin
		bwe = 1'b0;
		bwd = pk_byte;
		if (do_put && pk_push && bc_q < 7'(ssrp_pkg::MAX_DATA)) bwe = 1'b1;
		if (st_q == ssrp_pkg::ST_CLOSE) begin
			bwd = close_pad ? 8'd0 : 8'(acc_q << free_q);
			bwe = bc_q < 7'(ssrp_pkg::MAX_DATA);
		end
	end
	logic padz_q;
	assign close_pad = padz_q ? 1'b1 : (free_q == 4'd8);

	logic [7:0] total_q;
	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ssrp_pkg::ST_LOAD;
			mode_q <= ssrp_pkg::MODE_LIT;
			cbits_q <= 3'd4;
			cnt_q <= '0;
			seen_q <= 1'b0;
			lastop_q <= '0;
			acc_q <= 8'd0;
			free_q <= 4'd8;
			bc_q <= 7'd0;
			out_valid <= 1'b0;
			padz_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == ssrp_pkg::REG_CBITS[0]) cbits_q <= pwdata[2:0];
				else mode_q <= pwdata[1:0];
			end
			if (do_put) begin
				acc_q <= pk_acc;
				free_q <= pk_free;
				if (bwe) bc_q <= bc_q + 7'd1;
			end
			unique case (st_q)
				ssrp_pkg::ST_LOAD: if (in_acc) begin
					if (lwe) begin
						cnt_q <= cnt_q + 1'b1;
						if (in_data.opaque) begin
							lastop_q <= cnt_q;
							seen_q <= 1'b1;
						end
					end
					if (in_data.line_end) st_q <= ssrp_pkg::ST_SETUP;
				end
				ssrp_pkg::ST_SETUP: begin
					acc_q <= 8'd0;
					free_q <= 4'd8;
					bc_q <= 7'd0;
					padz_q <= 1'b0;
					pos_q <= '0;
					if (mode_q == ssrp_pkg::MODE_PACKED) begin
						len_q <= cnt_q;
						st_q <= ssrp_pkg::ST_ARD;
						alen_q <= '0;
					end else if (mode_q == ssrp_pkg::MODE_SHAPED) begin
						len_q <= !seen_q ? '0 : (lastop_q + 1'b1 < cnt_q ? lastop_q + 1'b1 : cnt_q);
						st_q <= ssrp_pkg::ST_ARD;
						alen_q <= '0;
					end else begin
						len_q <= cnt_q;
						lit_q <= 1'b1;
						n_q <= 5'd0;
						st_q <= ssrp_pkg::ST_PRD;
					end
					k_q <= '0;
				end
				ssrp_pkg::ST_ARD: begin
					// start a new analysis pass; alen_q zero means a fresh window
					if (pos_q >= len_q) begin
						st_q <= ssrp_pkg::ST_CLOSE;
					end else begin
						if (alen_q == '0) alen_q <= remw;
						k_q <= '0;
						run_q <= '0;
						longest_q <= WW'(1);
						lpos_q <= '0;
						prev_ok_q <= 1'b0;
						st_q <= ssrp_pkg::ST_ASCAN;
					end
				end
				ssrp_pkg::ST_ASCAN: begin
					// rd4 holds pixel pos+k-1 once k_q past zero
					if (k_q != '0) begin
						if (prev_ok_q && pv == prev_q) begin
							run_q <= a_inc_run;
							if (a_inc_run >= longest_q) begin
								longest_q <= a_inc_run;
								lpos_q <= k_q - a_inc_run;
							end
						end else begin
							prev_q <= pv;
							prev_ok_q <= 1'b1;
							run_q <= WW'(1);
						end
					end
					if (k_q == alen_q) st_q <= ssrp_pkg::ST_DEC;
					else k_q <= k_q + 1'b1;
				end
				ssrp_pkg::ST_DEC: begin
					k_q <= '0;
					if (longest_q == WW'(1)) begin
						lit_q <= 1'b1; n_q <= capf(alen_q); st_q <= ssrp_pkg::ST_HDR;
					end else if (lpos_q != '0 && (6'(lpos_q) + 6'(longest_q) > 6'd15)) begin
						alen_q <= lpos_q; st_q <= ssrp_pkg::ST_ARD;
					end else if (10'd5 + 10'(cb) < 10'(longest_q) * 10'(cb)) begin
						if (lpos_q == '0) begin
							lit_q <= 1'b0; n_q <= capf(longest_q); st_q <= ssrp_pkg::ST_HDR;
						end else begin
							alen_q <= lpos_q; st_q <= ssrp_pkg::ST_ARD;
						end
					end else begin
						lit_q <= 1'b1; n_q <= capf(alen_q); st_q <= ssrp_pkg::ST_HDR;
					end
				end
				ssrp_pkg::ST_HDR: st_q <= ssrp_pkg::ST_PRD;
				ssrp_pkg::ST_PRD: begin
					if (mode_q != ssrp_pkg::MODE_PACKED && mode_q != ssrp_pkg::MODE_SHAPED
						&& pos_q >= len_q) st_q <= ssrp_pkg::ST_CLOSE;
					else st_q <= ssrp_pkg::ST_PIX;
				end
				ssrp_pkg::ST_PIX: begin
					if (!lit_q) begin
						pos_q <= pos_q + CW'(n_q);
						alen_q <= '0;
						st_q <= ssrp_pkg::ST_ARD;
					end else begin
						pos_q <= pos_q + 1'b1;
						if (mode_q != ssrp_pkg::MODE_PACKED && mode_q != ssrp_pkg::MODE_SHAPED)
							st_q <= ssrp_pkg::ST_PRD;
						else if (n_q == 5'd1) begin
							alen_q <= '0; st_q <= ssrp_pkg::ST_ARD;
						end else begin
							n_q <= n_q - 5'd1; st_q <= ssrp_pkg::ST_PRD;
						end
					end
				end
				ssrp_pkg::ST_CLOSE: begin
					if (bwe) bc_q <= bc_q + 7'd1;
					acc_q <= 8'd0;
					free_q <= 4'd8;
					if (bc_q + 7'(bwe) == 7'd1 && !padz_q) begin
						padz_q <= 1'b1;
					end else begin
						total_q <= 8'(bc_q + 7'(bwe) + 7'd1);
						ei_q <= 7'd0;
						first_q <= 1'b1;
						out_valid <= 1'b1;
						st_q <= ssrp_pkg::ST_EMIT;
					end
				end
				ssrp_pkg::ST_EMIT: if (out_valid && out_ready) begin
					if (ei_q + 7'd1 == 7'(total_q)) begin
						out_valid <= 1'b0;
						cnt_q <= '0;
						seen_q <= 1'b0;
						lastop_q <= '0;
						st_q <= ssrp_pkg::ST_LOAD;
					end else begin
						out_valid <= 1'b0;
						st_q <= ssrp_pkg::ST_ERD;
					end
				end
				ssrp_pkg::ST_ERD: begin
					first_q <= 1'b0;
					ei_q <= ei_q + 7'd1;
					out_valid <= 1'b1;
					st_q <= ssrp_pkg::ST_EMIT;
				end
				default: st_q <= ssrp_pkg::ST_LOAD;
			endcase
		end
	end
	// byte index ei_q>0 shows data byte ei_q-1, read during ST_ERD
	assign out_data.out_byte = first_q ? total_q : rd8;
	assign out_data.final_byte = (ei_q + 7'd1 == 7'(total_q));

	`SSRP_ASSERT_IMP(a_ready_only_load, arst_n, in_ready, !out_valid)
	`SSRP_ASSERT_IMP(a_bc_bound, arst_n, 1'b1, bc_q <= 7'd63)
	`SSRP_ASSERT_NXT(a_load_end, arst_n, in_acc && in_data.line_end, st_q == ssrp_pkg::ST_SETUP)
endmodule
